// ----- rtl/spq_pkg.sv -----
// shared constants, types and codes for the priority queue
`default_nettype none
package spq_pkg;
  localparam int CAPACITY = 128;
  localparam int POS_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ID_W     = 31;
  localparam int PRIO_W   = 3;
  localparam int OPRI_W   = 2;
  localparam int ARR_W    = 8;
  localparam int OPOS_W   = 7;
  localparam int STAT_W   = 3;
  localparam int CMD_W    = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_SERVE  = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_DUP       = 3'd2,
    ST_ZERO_ID   = 3'd3,
    ST_BAD_PRIO  = 3'd4,
    ST_NONE_WAIT = 3'd5,
    ST_NOT_FOUND = 3'd6
  } status_e;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_t;

  typedef struct packed {
    logic has_result;
  } stat_t;
endpackage
`default_nettype wire

// ----- rtl/spq_in_if.sv -----
// command channel of the priority queue
`default_nettype none
interface spq_in_if;
  logic                         valid;
  logic                         ready;
  logic [spq_pkg::CMD_W-1:0]    cmd;
  logic [spq_pkg::ID_W-1:0]     patient_id;
  logic [spq_pkg::PRIO_W-1:0]   priority_level;
  modport source (output valid, cmd, patient_id, priority_level, input ready);
  modport sink   (input valid, cmd, patient_id, priority_level, output ready);
endinterface
`default_nettype wire

// ----- rtl/spq_out_if.sv -----
// result channel of the priority queue
`default_nettype none
interface spq_out_if;
  logic                         valid;
  logic                         ready;
  logic [spq_pkg::STAT_W-1:0]   status;
  logic [spq_pkg::ID_W-1:0]     out_id;
  logic [spq_pkg::OPRI_W-1:0]   out_priority;
  logic [spq_pkg::ARR_W-1:0]    out_arrival;
  logic                         out_served;
  logic [spq_pkg::OPOS_W-1:0]   out_position;
  modport source (output valid, status, out_id, out_priority, out_arrival, out_served,
                  out_position, input ready);
  modport sink   (input valid, status, out_id, out_priority, out_arrival, out_served,
                  out_position, output ready);
endinterface
`default_nettype wire

// ----- rtl/spq_ctrl.sv -----
// sequencing state machine of the priority queue
`default_nettype none
module spq_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire spq_pkg::stat_t stat_i,
  output spq_pkg::ctrl_t      ctrl_o
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_OUT  = 3'b100
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o   = (state_q == S_IDLE) || ((state_q == S_OUT) && out_ready_i);
  assign out_valid_o  = (state_q == S_OUT);
  assign ctrl_o.load  = in_valid_i && in_ready_o;
  assign ctrl_o.exec  = (state_q == S_EXEC);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (ctrl_o.load) state_d = S_EXEC;
      S_EXEC: state_d = stat_i.has_result ? S_OUT : S_IDLE;
      S_OUT: begin
        if (out_ready_i) state_d = ctrl_o.load ? S_EXEC : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end
endmodule
`default_nettype wire

// ----- rtl/spq_dp.sv -----
// row of entry cells with parallel compare, shift and result register
`default_nettype none
module spq_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire spq_pkg::ctrl_t              ctrl_i,
  output spq_pkg::stat_t                   stat_o,
  input  wire logic [spq_pkg::CMD_W-1:0]   cmd_i,
  input  wire logic [spq_pkg::ID_W-1:0]    id_i,
  input  wire logic [spq_pkg::PRIO_W-1:0]  prio_i,
  output logic [spq_pkg::STAT_W-1:0]       status_o,
  output logic [spq_pkg::ID_W-1:0]         out_id_o,
  output logic [spq_pkg::OPRI_W-1:0]       out_priority_o,
  output logic [spq_pkg::ARR_W-1:0]        out_arrival_o,
  output logic                             out_served_o,
  output logic [spq_pkg::OPOS_W-1:0]       out_position_o
);
  localparam int CAP   = spq_pkg::CAPACITY;
  localparam int POS_W = spq_pkg::POS_W;
  localparam int CNT_W = spq_pkg::CNT_W;

  logic [spq_pkg::CMD_W-1:0]  cmd_q;
  logic [spq_pkg::ID_W-1:0]   id_q;
  logic [spq_pkg::PRIO_W-1:0] prio_q;

  logic [spq_pkg::ID_W-1:0]   ids_q [CAP];
  logic [spq_pkg::OPRI_W-1:0] pri_q [CAP];
  logic [spq_pkg::ARR_W-1:0]  arr_q [CAP];
  logic [CNT_W-1:0] count_q, count_d, served_q, served_d;

  logic [CAP-1:0] match, gt, ins;
  logic [POS_W-1:0] hit_pos, ins_pos, srv_pos;
  logic [spq_pkg::ID_W-1:0]   hit_id;
  logic [spq_pkg::OPRI_W-1:0] hit_pri;
  logic [spq_pkg::ARR_W-1:0]  hit_arr;
  logic any_hit, full, prio_ok, waiting_any, do_ins, do_srv;
  logic [31:0] arr_wide, pos_wide;

  logic [spq_pkg::STAT_W-1:0] status_d;
  logic [spq_pkg::ID_W-1:0]   rid_d;
  logic [spq_pkg::OPRI_W-1:0] rpri_d;
  logic [spq_pkg::ARR_W-1:0]  rarr_d;
  logic                       rsrv_d;
  logic [spq_pkg::OPOS_W-1:0] rpos_d;

  assign stat_o.has_result = (cmd_q == spq_pkg::CMD_INSERT) ||
                             (cmd_q == spq_pkg::CMD_SERVE) ||
                             (cmd_q == spq_pkg::CMD_LOOKUP);

  // per-cell compare
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      match[i] = (CNT_W'(i) < count_q) && (ids_q[i] == id_q);
      gt[i]    = ((CNT_W'(i) < count_q) && (CNT_W'(i) >= served_q) &&
                  ({1'b0, pri_q[i]} > prio_q)) || (CNT_W'(i) == count_q);
    end
    ins[0] = gt[0];
    for (int i = 1; i < CAP; i++) ins[i] = gt[i] && !gt[i-1];
  end

  // encoders, at most one cell set in each vector
  always_comb begin
    hit_pos = '0;
    ins_pos = '0;
    hit_id  = '0;
    hit_pri = '0;
    hit_arr = '0;
    for (int i = 0; i < CAP; i++) begin
      if (match[i]) begin
        hit_pos |= POS_W'(i);
        hit_id  |= ids_q[i];
        hit_pri |= pri_q[i];
        hit_arr |= arr_q[i];
      end
      if (ins[i]) ins_pos |= POS_W'(i);
    end
  end

  assign any_hit     = |match;
  assign full        = (count_q == CNT_W'(CAP));
  assign prio_ok     = (prio_q != '0) && (prio_q <= spq_pkg::PRIO_W'(3));
  assign waiting_any = (served_q < count_q);
  assign srv_pos     = served_q[POS_W-1:0];
  assign arr_wide    = 32'(count_q) + 32'd1;

  always_comb begin
    status_d = spq_pkg::ST_OK;
    rid_d    = '0;
    rpri_d   = '0;
    rarr_d   = '0;
    rsrv_d   = 1'b0;
    pos_wide = '0;
    do_ins   = 1'b0;
    do_srv   = 1'b0;
    case (cmd_q)
      spq_pkg::CMD_INSERT: begin
        if (full)             status_d = spq_pkg::ST_FULL;
        else if (id_q == '0)  status_d = spq_pkg::ST_ZERO_ID;
        else if (any_hit)     status_d = spq_pkg::ST_DUP;
        else if (!prio_ok)    status_d = spq_pkg::ST_BAD_PRIO;
        else begin
          do_ins   = 1'b1;
          rarr_d   = arr_wide[spq_pkg::ARR_W-1:0];
          pos_wide = 32'(ins_pos);
        end
      end
      spq_pkg::CMD_SERVE: begin
        if (!waiting_any) status_d = spq_pkg::ST_NONE_WAIT;
        else begin
          do_srv   = 1'b1;
          rid_d    = ids_q[srv_pos];
          rpri_d   = pri_q[srv_pos];
          rarr_d   = arr_q[srv_pos];
          rsrv_d   = 1'b1;
          pos_wide = 32'(srv_pos);
        end
      end
      spq_pkg::CMD_LOOKUP: begin
        if (id_q == '0)    status_d = spq_pkg::ST_ZERO_ID;
        else if (!any_hit) status_d = spq_pkg::ST_NOT_FOUND;
        else begin
          rid_d    = hit_id;
          rpri_d   = hit_pri;
          rarr_d   = hit_arr;
          rsrv_d   = (CNT_W'(hit_pos) < served_q);
          pos_wide = 32'(hit_pos);
        end
      end
      default: ;
    endcase
    rpos_d = pos_wide[spq_pkg::OPOS_W-1:0];
  end

  assign count_d  = count_q + CNT_W'(do_ins);
  assign served_d = served_q + CNT_W'(do_srv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      served_q <= '0;
    end else if (ctrl_i.exec) begin
      count_q  <= count_d;
      served_q <= served_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q  <= cmd_i;
      id_q   <= id_i;
      prio_q <= prio_i;
    end
    if (ctrl_i.exec) begin
      status_o       <= status_d;
      out_id_o       <= rid_d;
      out_priority_o <= rpri_d;
      out_arrival_o  <= rarr_d;
      out_served_o   <= rsrv_d;
      out_position_o <= rpos_d;
    end
  end

  // cell shift on insert: cells between the slot and the tail move back one
  for (genvar g = 0; g < CAP; g++) begin : g_cell
    always_ff @(posedge clk_i) begin
      if (ctrl_i.exec && do_ins) begin
        if (ins[g]) begin
          ids_q[g] <= id_q;
          pri_q[g] <= prio_q[spq_pkg::OPRI_W-1:0];
          arr_q[g] <= arr_wide[spq_pkg::ARR_W-1:0];
        end else if (gt[g] && (g > 0)) begin
          ids_q[g] <= ids_q[(g > 0) ? g - 1 : 0];
          pri_q[g] <= pri_q[(g > 0) ? g - 1 : 0];
          arr_q[g] <= arr_q[(g > 0) ? g - 1 : 0];
        end
      end
    end
  end

  a_served_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    served_q <= count_q) else $error("served prefix past entry count");
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAP)) else $error("entry count above capacity");
  a_served_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.exec |=> (served_q == $past(served_q)) ||
                    (served_q == $past(served_q) + CNT_W'(1)))
    else $error("served count jumped");
  a_unique_ids: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match)) else $error("id present in more than one cell");
endmodule
`default_nettype wire

// ----- rtl/stable_priority_queue_with_lookup_unit.sv -----
// top level of the stable three-level priority queue with id lookup
//
// channel | dir | fields
// in_i    | in  | cmd, patient_id, priority_level
// out_o   | out | status, out_id, out_priority, out_arrival, out_served, out_position
//
// an item is taken in one cycle and evaluated in the next against all cells at once
// a result is registered during evaluation and held until taken; the next item is taken in the
// cycle the result leaves, so no new item is taken while one is still being evaluated
// the store needs no clearing after reset: only counts are cleared
// a stalled result holds the block; command three gives no result
`default_nettype none
module stable_priority_queue_with_lookup_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  spq_in_if.sink    in_i,
  spq_out_if.source out_o
);
  spq_pkg::ctrl_t ctrl;
  spq_pkg::stat_t stat;

  // sequencing: accept, evaluate, hold result
  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  // entry cells, counters and the result register
  spq_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .cmd_i          (in_i.cmd),
    .id_i           (in_i.patient_id),
    .prio_i         (in_i.priority_level),
    .status_o       (out_o.status),
    .out_id_o       (out_o.out_id),
    .out_priority_o (out_o.out_priority),
    .out_arrival_o  (out_o.out_arrival),
    .out_served_o   (out_o.out_served),
    .out_position_o (out_o.out_position)
  );
endmodule
`default_nettype wire

// ----- bench/spq_tb_if.sv -----
// bench helper package with command and answer records for the queue
`default_nettype none
package spq_tb_pkg;
  import spq_pkg::*;

  typedef struct packed {
    cmd_e                 cmd;
    logic [ID_W-1:0]      id;
    logic [PRIO_W-1:0]    prio;
  } command_t;

  typedef struct packed {
    status_e              status;
    logic [ID_W-1:0]      id;
    logic [OPRI_W-1:0]    prio;
    logic [ARR_W-1:0]     arrival;
    logic                 served;
    logic [OPOS_W-1:0]    position;
  } answer_t;
endpackage
`default_nettype wire

// ----- bench/testbench.sv -----
// self-checking bench for the stable priority queue with id lookup
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;
  import spq_tb_pkg::*;

  localparam int LIMIT_CYCLES = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  spq_in_if  in_ch();
  spq_out_if out_ch();

  stable_priority_queue_with_lookup_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // shadow of the queue store
  logic [ID_W-1:0]   q_ids   [CAPACITY];
  logic [OPRI_W-1:0] q_prios [CAPACITY];
  logic [ARR_W-1:0]  q_arrs  [CAPACITY];
  int                q_count;
  int                q_served;

  command_t pending_cmds[$];
  answer_t  awaited[$];

  int  send_idle_pct, recv_stall_pct;
  int  errors, answers_seen, cycles;

  // position of an id in the store, q_count when absent
  function automatic int locate(logic [ID_W-1:0] id);
    for (int i = 0; i < q_count; i++)
      if (q_ids[i] == id) return i;
    return q_count;
  endfunction

  // advance the shadow queue by one command and give what it answers
  function automatic bit queue_predict(command_t c, output answer_t a);
    int pos;
    a = '0;
    a.status = ST_OK;
    case (c.cmd)
      CMD_INSERT: begin
        if (q_count >= CAPACITY) a.status = ST_FULL;
        else if (c.id == 0) a.status = ST_ZERO_ID;
        else if (locate(c.id) < q_count) a.status = ST_DUP;
        else if (c.prio < 1 || c.prio > 3) a.status = ST_BAD_PRIO;
        else begin
          pos = q_count;
          // less urgent waiting entries move one place back
          while (pos > q_served && q_prios[pos-1] > c.prio[OPRI_W-1:0]) begin
            q_ids[pos]   = q_ids[pos-1];
            q_prios[pos] = q_prios[pos-1];
            q_arrs[pos]  = q_arrs[pos-1];
            pos--;
          end
          q_ids[pos]   = c.id;
          q_prios[pos] = c.prio[OPRI_W-1:0];
          q_arrs[pos]  = ARR_W'(q_count + 1);
          a.arrival    = ARR_W'(q_count + 1);
          a.position   = OPOS_W'(pos);
          q_count++;
        end
      end
      CMD_SERVE: begin
        if (q_served >= q_count) a.status = ST_NONE_WAIT;
        else begin
          a.id       = q_ids[q_served];
          a.prio     = q_prios[q_served];
          a.arrival  = q_arrs[q_served];
          a.served   = 1'b1;
          a.position = OPOS_W'(q_served);
          q_served++;
        end
      end
      CMD_LOOKUP: begin
        if (c.id == 0) a.status = ST_ZERO_ID;
        else begin
          pos = locate(c.id);
          if (pos >= q_count) a.status = ST_NOT_FOUND;
          else begin
            a.id       = q_ids[pos];
            a.prio     = q_prios[pos];
            a.arrival  = q_arrs[pos];
            a.served   = (pos < q_served);
            a.position = OPOS_W'(pos);
          end
        end
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // driver: next item from the pending queue, valid held until taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid          <= 1'b0;
      in_ch.cmd            <= '0;
      in_ch.patient_id     <= '0;
      in_ch.priority_level <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        command_t c;
        c = pending_cmds.pop_front();
        in_ch.valid          <= 1'b1;
        in_ch.cmd            <= c.cmd;
        in_ch.patient_id     <= c.id;
        in_ch.priority_level <= c.prio;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // prediction on every accepted item
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      command_t c;
      answer_t  a;
      c.cmd  = cmd_e'(in_ch.cmd);
      c.id   = in_ch.patient_id;
      c.prio = in_ch.priority_level;
      if (queue_predict(c, a)) awaited.push_back(a);
    end
  end

  // receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      answer_t got, exp_a;
      got.status   = status_e'(out_ch.status);
      got.id       = out_ch.out_id;
      got.prio     = out_ch.out_priority;
      got.arrival  = out_ch.out_arrival;
      got.served   = out_ch.out_served;
      got.position = out_ch.out_position;
      answers_seen++;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t unexpected result %p", $time, got);
      end else begin
        exp_a = awaited.pop_front();
        if (got.status   !== exp_a.status   || got.id       !== exp_a.id ||
            got.prio     !== exp_a.prio     || got.arrival  !== exp_a.arrival ||
            got.served   !== exp_a.served   || got.position !== exp_a.position) begin
          errors++;
          $display("%0t mismatch expected %p actual %p", $time, exp_a, got);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("[stable_priority_queue_with_lookup_unit] ERROR");
      $finish;
    end
  end

  // tracks which ids went in so lookups and duplicates hit
  logic [ID_W-1:0] used_ids[$];

  function automatic logic [ID_W-1:0] fresh_id();
    logic [ID_W-1:0] v;
    case ($urandom_range(3))
      0: v = ID_W'($urandom_range(1, 300));
      1: v = {1'b1, (ID_W-1)'($urandom)};
      default: v = ID_W'($urandom);
    endcase
    if (v == 0) v = 1;
    return v;
  endfunction

  function automatic logic [ID_W-1:0] known_id();
    if (used_ids.size() == 0) return fresh_id();
    return used_ids[$urandom_range(used_ids.size() - 1)];
  endfunction

  task automatic add_cmd(cmd_e c, logic [ID_W-1:0] id, logic [PRIO_W-1:0] p);
    command_t x;
    x.cmd = c; x.id = id; x.prio = p;
    if (c == CMD_INSERT) used_ids.push_back(id);
    pending_cmds.push_back(x);
  endtask

  task automatic add_raw(logic [CMD_W-1:0] c, logic [ID_W-1:0] id, logic [PRIO_W-1:0] p);
    command_t x;
    x.cmd = cmd_e'(c); x.id = id; x.prio = p;
    pending_cmds.push_back(x);
  endtask

  // one session: a burst of inserts and serves with lookups mixed in
  task automatic add_session(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 45) add_cmd(CMD_INSERT, fresh_id(), PRIO_W'($urandom_range(1, 3)));
      else if (k < 65) add_cmd(CMD_SERVE, ID_W'($urandom), PRIO_W'($urandom));
      else if (k < 85) add_cmd(CMD_LOOKUP, known_id(), PRIO_W'($urandom));
      else if (k < 89) add_cmd(CMD_LOOKUP, fresh_id(), PRIO_W'($urandom));
      else if (k < 92) add_cmd(CMD_INSERT, known_id(), PRIO_W'($urandom_range(1, 3)));
      else if (k < 95) add_cmd(CMD_INSERT, fresh_id(), PRIO_W'($urandom_range(4, 7)));
      else if (k < 97) add_cmd(CMD_INSERT, fresh_id(), 3'd0);
      else if (k < 98) add_cmd(CMD_INSERT, '0, PRIO_W'($urandom));
      else if (k < 99) add_cmd(CMD_LOOKUP, '0, PRIO_W'($urandom));
      else add_raw(2'd3, ID_W'($urandom), PRIO_W'($urandom));
    end
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_ch.valid || awaited.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    q_count = 0; q_served = 0;
    errors = 0; answers_seen = 0; cycles = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty-store cases, every status but full, field extremes, stable order
    add_cmd(CMD_SERVE, '0, '0);
    add_cmd(CMD_LOOKUP, 31'h7fff_ffff, 3'd7);
    add_cmd(CMD_LOOKUP, '0, '0);
    add_cmd(CMD_INSERT, '0, 3'd1);
    add_cmd(CMD_INSERT, 31'd5, 3'd0);
    add_cmd(CMD_INSERT, 31'd5, 3'd7);
    add_cmd(CMD_INSERT, 31'd5, 3'd4);
    add_cmd(CMD_INSERT, 31'h7fff_ffff, 3'd3);
    add_cmd(CMD_INSERT, 31'd1, 3'd3);
    add_cmd(CMD_INSERT, 31'h2aaa_aaaa, 3'd2);
    add_cmd(CMD_INSERT, 31'h5555_5555, 3'd1);
    add_cmd(CMD_INSERT, 31'd7, 3'd1);
    add_cmd(CMD_INSERT, 31'd1, 3'd2);
    add_raw(2'd3, 31'h7fff_ffff, 3'd7);
    add_cmd(CMD_LOOKUP, 31'h7fff_ffff, '0);
    add_cmd(CMD_SERVE, '0, '0);
    add_cmd(CMD_SERVE, '0, '0);
    add_cmd(CMD_LOOKUP, 31'h5555_5555, '0);
    add_cmd(CMD_INSERT, 31'h5555_5555, 3'd1);
    add_cmd(CMD_INSERT, 31'd9, 3'd1);
    add_cmd(CMD_LOOKUP, 31'd9, '0);
    add_cmd(CMD_LOOKUP, 31'd12345, '0);
    wait_drained();

    // random phases with different idling; the store already fills in the first one
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      add_session(ph == 3 ? 250 : 350);
      wait_drained();
    end

    // fill the store to the brim, then insert past it and drain the waiters
    send_idle_pct = 0; recv_stall_pct = 0;
    while (q_count + pending_cmds.size() < CAPACITY + 4)
      add_cmd(CMD_INSERT, fresh_id(), PRIO_W'($urandom_range(1, 3)));
    add_cmd(CMD_INSERT, fresh_id(), 3'd7);
    add_cmd(CMD_LOOKUP, known_id(), '0);
    for (int i = 0; i < 140; i++) add_cmd(CMD_SERVE, '0, '0);
    for (int i = 0; i < 20; i++) add_cmd(CMD_LOOKUP, known_id(), '0);
    wait_drained();

    $display("covered %0d results, %0d entries stored, %0d served, store filled to %0d",
             answers_seen, q_count, q_served, q_count);
    if (errors == 0) begin
      $display("[stable_priority_queue_with_lookup_unit] OK");
    end else begin
      $display("[stable_priority_queue_with_lookup_unit] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
